### rtl/vwbl_pkg.sv
package vwbl_pkg;

  // default edge table size in bins
  localparam int MAX_BINS_DEF = 256;

  // pointer field width in a command, wide enough for any edge position up to 4096
  localparam int PTR_W = 13;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_NOINIT = 2'd2,
    ST_ORDER  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_REPLY  = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_kind_t;

  // ptr: write address for CMD_WRITE, upper search bound for CMD_SEARCH
  typedef struct packed {
    cmd_kind_t          kind;
    status_t            status;
    logic [PTR_W-1:0]   ptr;
    logic signed [31:0] value;
    logic signed [31:0] first_edge;
    logic signed [31:0] last_edge;
  } cmd_t;

endpackage

### rtl/vwbl_front.sv
module vwbl_front #(
  parameter int MAX_BINS = vwbl_pkg::MAX_BINS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [8:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [8:0]          in_edge_index,
  input  logic signed [31:0]  in_value,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output vwbl_pkg::cmd_t      cmd
);
  import vwbl_pkg::*;

  localparam int CNT_W = $clog2(MAX_BINS + 2);

  logic [8:0]         bin_count_r;
  logic [CNT_W-1:0]   loaded_r, loaded_nxt;
  logic               fault_r, fault_nxt;
  logic signed [31:0] first_r, first_nxt;
  logic signed [31:0] last_r, last_nxt;
  logic [CNT_W-1:0]   eff_bins;
  logic [CNT_W-1:0]   needed;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid & cmd_ready;

  // zero acts as one bin, anything above the table size saturates
  always_comb begin
    if (bin_count_r == 9'd0) begin
      eff_bins = CNT_W'(1);
    end else if (32'(bin_count_r) > MAX_BINS) begin
      eff_bins = CNT_W'(MAX_BINS);
    end else begin
      eff_bins = CNT_W'(bin_count_r);
    end
  end

  assign needed = eff_bins + CNT_W'(1);

  always_comb begin
    loaded_nxt     = loaded_r;
    fault_nxt      = fault_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    cmd.kind       = CMD_REPLY;
    cmd.status     = ST_OK;
    cmd.ptr        = '0;
    cmd.value      = in_value;
    cmd.first_edge = first_r;
    cmd.last_edge  = last_r;
    if (in_op == OP_LOAD) begin
      if (in_edge_index == 9'd0) begin
        // restart of the table
        fault_nxt  = 1'b0;
        first_nxt  = in_value;
        last_nxt   = in_value;
        loaded_nxt = CNT_W'(1);
        cmd.kind   = CMD_WRITE;
      end else if (fault_r) begin
        cmd.status = ST_ORDER;
      end else if (32'(in_edge_index) != 32'(loaded_r) ||
                   32'(in_edge_index) >= 32'(needed) ||
                   32'(in_edge_index) > MAX_BINS ||
                   in_value <= last_r) begin
        fault_nxt  = 1'b1;
        cmd.status = ST_ORDER;
      end else begin
        cmd.kind   = CMD_WRITE;
        cmd.ptr    = PTR_W'(in_edge_index);
        loaded_nxt = CNT_W'(in_edge_index) + CNT_W'(1);
        last_nxt   = in_value;
      end
    end else begin
      if (fault_r || loaded_r != needed) begin
        cmd.status = ST_NOINIT;
      end else if (in_value < first_r || in_value >= last_r) begin
        cmd.status = ST_RANGE;
      end else begin
        cmd.kind = CMD_SEARCH;
        cmd.ptr  = PTR_W'(needed - CNT_W'(2));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= 9'd1;
      loaded_r    <= '0;
      fault_r     <= 1'b0;
    end else if (cfg_valid) begin
      bin_count_r <= cfg_data;
      loaded_r    <= '0;
      fault_r     <= 1'b0;
    end else if (accept) begin
      loaded_r <= loaded_nxt;
      fault_r  <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

### rtl/vwbl_queue.sv
module vwbl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  vwbl_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output vwbl_pkg::cmd_t pop_data
);
  import vwbl_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/vwbl_back.sv
module vwbl_back #(
  parameter int MAX_BINS = vwbl_pkg::MAX_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  vwbl_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [7:0]         out_bin,
  output logic signed [31:0] out_lower,
  output logic signed [31:0] out_upper
);
  import vwbl_pkg::*;

  localparam int DEPTH = MAX_BINS + 1;
  localparam int AW    = $clog2(MAX_BINS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_CMP
  } state_t;

  state_t             state_r;
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;
  logic [AW-1:0]      lo_r, hi_r, mid_r;
  logic signed [31:0] val_r, lower_r, upper_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [7:0]         out_bin_r;
  logic signed [31:0] out_lower_r, out_upper_r;
  logic [AW:0]        span;
  logic [AW-1:0]      mid;
  logic               out_free;
  logic               take;
  logic               res_load;

  // upper-biased midpoint of [lo, hi]
  assign span = {1'b0, hi_r} - {1'b0, lo_r} + (AW+1)'(1);
  assign mid  = lo_r + AW'(span >> 1);

  assign out_free  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE) && out_free;
  assign take      = cmd_valid && cmd_ready;

  // a result register is loaded either straight from a command or at the end of a search
  assign res_load = (take && cmd.kind != CMD_SEARCH) ||
                    (state_r == S_STEP && lo_r == hi_r && out_free);

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_bin    = out_bin_r;
  assign out_lower  = out_lower_r;
  assign out_upper  = out_upper_r;

  always_ff @(posedge clk) begin
    if (take && cmd.kind == CMD_WRITE) begin
      mem[cmd.ptr[AW-1:0]] <= cmd.value;
    end
    rd_data_r <= mem[mid];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            case (cmd.kind)
              CMD_SEARCH: begin
                lo_r    <= '0;
                hi_r    <= cmd.ptr[AW-1:0];
                val_r   <= cmd.value;
                lower_r <= cmd.first_edge;
                upper_r <= cmd.last_edge;
                state_r <= S_STEP;
              end
              default: begin
                out_status_r <= cmd.status;
                out_bin_r    <= '0;
                out_lower_r  <= '0;
                out_upper_r  <= '0;
              end
            endcase
          end
        end
        S_STEP: begin
          if (lo_r == hi_r) begin
            if (out_free) begin
              out_status_r <= ST_OK;
              out_bin_r    <= 8'(lo_r);
              out_lower_r  <= lower_r;
              out_upper_r  <= upper_r;
              state_r      <= S_IDLE;
            end
          end else begin
            mid_r   <= mid;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_data_r <= val_r) begin
            lo_r    <= mid_r;
            lower_r <= rd_data_r;
          end else begin
            hi_r    <= mid_r - AW'(1);
            upper_r <= rd_data_r;
          end
          state_r <= S_STEP;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/variable_width_bin_lookup_top.sv
// variable-width histogram bin lookup: edges are loaded one beat at a time in index
// order (signed Q16.16, each strictly above the one before) and lookup beats return
// the bin that holds the value with its lower and upper edge; the front end checks
// load order and range against a copy of the first and last edge and hands commands
// through a two-entry queue to the back end, which owns the edge memory; a load or a
// rejected lookup is answered straight from the command, while a lookup that needs the
// search reads the edge memory through its single read port, one read and one compare
// per halving step, and the back end takes no new command until the search is done; the
// input side keeps taking beats while the queue has room, even while a result waits
module variable_width_bin_lookup_top #(
  parameter int MAX_BINS = vwbl_pkg::MAX_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // bin count register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  // item beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // edge_index [8:0], value [40:9], zero fill above
  input  logic [0:0]  in_tuser,   // operation [0]
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // bin_index [7:0], lower_edge [39:8], upper_edge [71:40]
  output logic [1:0]  out_tuser   // status [1:0]
);
  import vwbl_pkg::*;

  // front end to queue
  logic               fq_valid;
  logic               fq_ready;
  cmd_t               fq_cmd;
  // queue to back end
  logic               qb_valid;
  logic               qb_ready;
  cmd_t               qb_cmd;
  // back end result fields
  logic [7:0]         res_bin;
  logic signed [31:0] res_lower;
  logic signed [31:0] res_upper;

  vwbl_front #(
    .MAX_BINS(MAX_BINS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (in_tuser[0]),
    .in_edge_index(in_tdata[8:0]),
    .in_value     (in_tdata[40:9]),
    .cmd_valid    (fq_valid),
    .cmd_ready    (fq_ready),
    .cmd          (fq_cmd)
  );

  // decouples classification from the search
  vwbl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data (fq_cmd),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_cmd)
  );

  vwbl_back #(
    .MAX_BINS(MAX_BINS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_status(out_tuser),
    .out_bin   (res_bin),
    .out_lower (res_lower),
    .out_upper (res_upper)
  );

  // pack result fields, lowest field first
  assign out_tdata = {res_upper, res_lower, res_bin};

`ifndef NO_ASSERTIONS
  // a result that is not ok carries an all-zero payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("non-ok result with nonzero payload");

  // a found bin always has its lower edge strictly below its upper edge
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OK && (res_lower != 0 || res_upper != 0)
    |-> res_lower < res_upper)
    else $error("found bin edges not increasing");

  // the front end never loses a command into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> fq_valid && fq_ready)
    else $error("accepted beat not pushed into queue");
`endif

endmodule
